@@ design/sha1bc_pkg.sv @@
`timescale 1ns / 1ps

package sha1bc_pkg;

    localparam int WORD_W       = 32;
    localparam int BLOCK_WORDS  = 16;
    localparam int ROUNDS       = 80;
    localparam int DIGEST_WORDS = 5;
    localparam int WCNT_W       = 4;
    localparam int RCNT_W       = 7;
    localparam int IDX_W        = 3;

    typedef logic [WORD_W-1:0] word_t;

    // standard initial chaining value
    localparam word_t IV0 = 32'h67452301;
    localparam word_t IV1 = 32'hefcdab89;
    localparam word_t IV2 = 32'h98badcfe;
    localparam word_t IV3 = 32'h10325476;
    localparam word_t IV4 = 32'hc3d2e1f0;

    // round groups of twenty rounds each
    typedef enum logic [1:0] {
        STG_CHOOSE  = 2'd0,
        STG_PARITY1 = 2'd1,
        STG_MAJ     = 2'd2,
        STG_PARITY2 = 2'd3
    } stage_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic   shift_in;    // item accepted, shift word into schedule
        logic   restart;     // reload initial chaining value
        logic   round_en;    // run one round
        logic   first_round; // take round inputs from chaining value
        logic   use_sched;   // expand schedule word from window taps
        stage_t stage;
        logic   finish;      // fold working regs into chain, load output buffer
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } dp_status_t;

    function automatic word_t round_const(input stage_t stg);
        word_t k;
        unique case (stg)
            STG_CHOOSE:  k = 32'h5a827999;
            STG_PARITY1: k = 32'h6ed9eba1;
            STG_MAJ:     k = 32'h8f1bbcdc;
            STG_PARITY2: k = 32'hca62c1d6;
            default:     k = 32'h5a827999;
        endcase
        return k;
    endfunction

    function automatic word_t round_fn(input stage_t stg, input word_t b,
                                       input word_t c, input word_t d);
        word_t f;
        unique case (stg)
            STG_CHOOSE:  f = (b & c) | (~b & d);
            STG_MAJ:     f = (b & c) | (b & d) | (c & d);
            default:     f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    function automatic word_t rotl(input word_t x, input int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

endpackage

@@ design/sha1_block_compression.sv @@
`timescale 1ns / 1ps
// after the sixteenth word of a block is taken, the 80 rounds run, then a finish step
// (held while the output buffer still holds the previous digest) before the first digest
// item is offered; blocks of 16 items share the single round unit, so no new word is
// taken until the rounds and finish of the current block are done; digest items drain
// from an output buffer while the next block loads
// reset: aresetn synchronous active low, chaining value returns to the initial value
module sha1_block_compression (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] message_word
    input  logic        s_tuser,   // [0] new_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] digest_index, zero fill
    output logic        m_tlast
);

    sha1bc_pkg::ctrl_cmd_t        cmd;
    sha1bc_pkg::dp_status_t       status;
    sha1bc_pkg::word_t            m_word;
    logic [sha1bc_pkg::IDX_W-1:0] m_index;

    sha1bc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_new_message (s_tuser),
        .s_tready      (s_tready),
        .status        (status),
        .cmd           (cmd)
    );

    sha1bc_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_word  (s_tdata),
        .m_word  (m_word),
        .m_index (m_index),
        .m_valid (m_tvalid),
        .m_ready (m_tready)
    );

    // pack result item
    assign m_tdata = {5'b0, m_index, m_word};
    assign m_tlast = (m_index == sha1bc_pkg::IDX_W'(sha1bc_pkg::DIGEST_WORDS - 1));

endmodule

@@ design/sha1bc_ctrl.sv @@
`timescale 1ns / 1ps

module sha1bc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_new_message,
    output logic                   s_tready,
    input  sha1bc_pkg::dp_status_t status,
    output sha1bc_pkg::ctrl_cmd_t  cmd
);

    sha1bc_pkg::state_t state_reg, state_next;
    logic [sha1bc_pkg::WCNT_W-1:0] word_cnt_reg, word_cnt_next;
    logic [sha1bc_pkg::RCNT_W-1:0] round_cnt_reg, round_cnt_next;

    logic                          accept;
    logic [sha1bc_pkg::WCNT_W-1:0] word_pos;
    logic                          last_word;
    logic                          last_round;

    assign accept     = s_tvalid && (state_reg == sha1bc_pkg::ST_LOAD);
    assign word_pos   = s_new_message ? '0 : word_cnt_reg;
    assign last_word  = (word_pos == sha1bc_pkg::WCNT_W'(sha1bc_pkg::BLOCK_WORDS - 1));
    assign last_round = (round_cnt_reg == sha1bc_pkg::RCNT_W'(sha1bc_pkg::ROUNDS - 1));

    // next state and counters
    always_comb begin
        state_next     = state_reg;
        word_cnt_next  = word_cnt_reg;
        round_cnt_next = round_cnt_reg;
        unique case (state_reg)
            sha1bc_pkg::ST_LOAD: begin
                if (accept) begin
                    word_cnt_next = word_pos + 1'b1;
                    if (last_word) begin
                        state_next     = sha1bc_pkg::ST_ROUND;
                        round_cnt_next = '0;
                    end
                end
            end
            sha1bc_pkg::ST_ROUND: begin
                round_cnt_next = round_cnt_reg + 1'b1;
                if (last_round) begin
                    state_next     = sha1bc_pkg::ST_FINISH;
                    round_cnt_next = '0;
                end
            end
            sha1bc_pkg::ST_FINISH: begin
                if (!status.out_busy) begin
                    state_next = sha1bc_pkg::ST_LOAD;
                end
            end
            default: state_next = sha1bc_pkg::ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        cmd             = '0;
        s_tready        = 1'b0;
        cmd.first_round = (round_cnt_reg == '0);
        cmd.use_sched   = (round_cnt_reg >= sha1bc_pkg::RCNT_W'(sha1bc_pkg::BLOCK_WORDS));
        if (round_cnt_reg < 7'd20) begin
            cmd.stage = sha1bc_pkg::STG_CHOOSE;
        end else if (round_cnt_reg < 7'd40) begin
            cmd.stage = sha1bc_pkg::STG_PARITY1;
        end else if (round_cnt_reg < 7'd60) begin
            cmd.stage = sha1bc_pkg::STG_MAJ;
        end else begin
            cmd.stage = sha1bc_pkg::STG_PARITY2;
        end
        unique case (state_reg)
            sha1bc_pkg::ST_LOAD: begin
                s_tready     = 1'b1;
                cmd.shift_in = accept;
                cmd.restart  = accept && s_new_message;
            end
            sha1bc_pkg::ST_ROUND: begin
                cmd.round_en = 1'b1;
            end
            sha1bc_pkg::ST_FINISH: begin
                cmd.finish = !status.out_busy;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sha1bc_pkg::ST_LOAD;
            word_cnt_reg  <= '0;
            round_cnt_reg <= '0;
        end else begin
            state_reg     <= state_next;
            word_cnt_reg  <= word_cnt_next;
            round_cnt_reg <= round_cnt_next;
        end
    end

endmodule

@@ design/sha1bc_datapath.sv @@
`timescale 1ns / 1ps

module sha1bc_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sha1bc_pkg::ctrl_cmd_t               cmd,
    output sha1bc_pkg::dp_status_t              status,
    input  sha1bc_pkg::word_t                   s_word,
    output sha1bc_pkg::word_t                   m_word,
    output logic [sha1bc_pkg::IDX_W-1:0]        m_index,
    output logic                                m_valid,
    input  logic                                m_ready
);

    localparam int NW = sha1bc_pkg::BLOCK_WORDS;
    localparam int ND = sha1bc_pkg::DIGEST_WORDS;

    sha1bc_pkg::word_t sched_reg [NW];
    sha1bc_pkg::word_t work_reg  [ND];
    sha1bc_pkg::word_t chain_reg [ND];
    sha1bc_pkg::word_t obuf_reg  [ND];
    logic [sha1bc_pkg::IDX_W-1:0] oidx_reg, oidx_next;
    logic                         ovalid_reg, ovalid_next;

    sha1bc_pkg::word_t iv [ND];
    sha1bc_pkg::word_t src [ND];
    sha1bc_pkg::word_t sum [ND];
    sha1bc_pkg::word_t w_cur;
    sha1bc_pkg::word_t tmp;
    logic              pop;

    assign iv[0] = sha1bc_pkg::IV0;
    assign iv[1] = sha1bc_pkg::IV1;
    assign iv[2] = sha1bc_pkg::IV2;
    assign iv[3] = sha1bc_pkg::IV3;
    assign iv[4] = sha1bc_pkg::IV4;

    // schedule word: oldest entry for the first sixteen rounds, then expanded
    assign w_cur = cmd.use_sched
                 ? sha1bc_pkg::rotl(sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0], 1)
                 : sched_reg[0];

    // round inputs and new a value
    always_comb begin
        for (int i = 0; i < ND; i++) begin
            src[i] = cmd.first_round ? chain_reg[i] : work_reg[i];
            sum[i] = chain_reg[i] + work_reg[i];
        end
        tmp = sha1bc_pkg::rotl(src[0], 5)
            + sha1bc_pkg::round_fn(cmd.stage, src[1], src[2], src[3])
            + src[4] + w_cur + sha1bc_pkg::round_const(cmd.stage);
    end

    // schedule window as a shift line, words enter at the top
    always_ff @(posedge aclk) begin
        if (cmd.shift_in || cmd.round_en) begin
            for (int i = 0; i < NW - 1; i++) begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[NW-1] <= cmd.shift_in ? s_word : w_cur;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.round_en) begin
            work_reg[0] <= tmp;
            work_reg[1] <= src[0];
            work_reg[2] <= sha1bc_pkg::rotl(src[1], 30);
            work_reg[3] <= src[2];
            work_reg[4] <= src[3];
        end
    end

    // chaining value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ND; i++) chain_reg[i] <= iv[i];
        end else if (cmd.restart) begin
            for (int i = 0; i < ND; i++) chain_reg[i] <= iv[i];
        end else if (cmd.finish) begin
            for (int i = 0; i < ND; i++) chain_reg[i] <= sum[i];
        end
    end

    // output buffer control
    assign pop = ovalid_reg && m_ready;

    always_comb begin
        oidx_next   = oidx_reg;
        ovalid_next = ovalid_reg;
        if (cmd.finish) begin
            oidx_next   = '0;
            ovalid_next = 1'b1;
        end else if (pop) begin
            oidx_next = oidx_reg + 1'b1;
            if (oidx_reg == sha1bc_pkg::IDX_W'(ND - 1)) begin
                ovalid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oidx_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            oidx_reg   <= oidx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // output words shift down as they are taken
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            for (int i = 0; i < ND; i++) obuf_reg[i] <= sum[i];
        end else if (pop) begin
            for (int i = 0; i < ND - 1; i++) obuf_reg[i] <= obuf_reg[i+1];
            obuf_reg[ND-1] <= obuf_reg[ND-1];
        end
    end

    assign m_word          = obuf_reg[0];
    assign m_index         = oidx_reg;
    assign m_valid         = ovalid_reg;
    assign status.out_busy = ovalid_reg;

endmodule
